// ===== rtl/srbl_pkg.sv =====
// Shared types and constants of the branch log likelihood accumulator.
package srbl_pkg;

  localparam int MAX_STATES = 4;
  localparam int LANES      = 4;
  localparam int LANE_LIMIT = (MAX_STATES < LANES) ? MAX_STATES : LANES;

  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [31:0] LOG2E_Q16 = 32'd94548;
  localparam logic [3:0]  EXP_TERMS = 4'd8;
  localparam logic [3:0]  LOG_LAST  = 4'd15;

  // Reciprocals for the series divide: ceil(2^s / n), exact below 2^31
  localparam logic [31:0] RECIP_1 = 32'h8000_0000;
  localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP_7 = 32'h9249_2493;

  localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ACC_MIN = -ACC_MAX - 49'sd1;

  typedef enum logic [2:0] {
    REG_NUM_STATES = 3'd0,
    REG_LAMBDA_0   = 3'd1,
    REG_LAMBDA_1   = 3'd2,
    REG_LAMBDA_2   = 3'd3,
    REG_LAMBDA_3   = 3'd4
  } cfg_idx_t;

  typedef logic [LANES-1:0][23:0] lam_arr_t;

  typedef struct packed {
    logic [23:0] branch_length;
    logic        is_tip;
    logic        is_root;
    logic [31:0] partial_0;
    logic [31:0] partial_1;
    logic [31:0] partial_2;
    logic [31:0] partial_3;
    logic        last_node;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] log_likelihood;
    logic               invalid;
  } out_item_t;

  // One classified node as it waits between front and back.
  typedef struct packed {
    logic [23:0]            len;
    logic                   tip;
    logic                   root;
    logic                   last;
    logic                   zsum;
    logic [2:0]             n;
    logic [33:0]            sum;
    logic [LANES-1:0][31:0] partial;
  } node_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [34:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/state_rate_branch_loglik.sv =====
// Top level: configuration registers, front end, node queue, back end and divider.
//
// Each tree node beat is summed and classified on entry, then waits in a
// two-entry queue while the back end works. A root node, or one whose partial
// sum is zero, goes straight to the finish state. For any other node, per
// active state the shared one-bit-a-cycle divider runs up to three times
// (rate ratio, weight, normalised partial), tips skipping the weight, the exp
// series takes eight steps through the shared 32x32 multiplier, and the log
// walks the node total into place and then takes 16 squarings.
// A result beat appears only for the node marked last; config writes are
// always ready and must be made while the block is idle.
module state_rate_branch_loglik (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srbl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srbl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import srbl_pkg::*;

  logic [2:0] num_states_r;
  lam_arr_t   lambda_r;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  node_t      q_in;
  node_t      q_out;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= 3'd2;
      lambda_r     <= {LANES{24'd65536}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_STATES: num_states_r <= cfg_data[2:0];
        REG_LAMBDA_0:   lambda_r[0]  <= cfg_data;
        REG_LAMBDA_1:   lambda_r[1]  <= cfg_data;
        REG_LAMBDA_2:   lambda_r[2]  <= cfg_data;
        REG_LAMBDA_3:   lambda_r[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  srbl_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .num_states (num_states_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  srbl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  srbl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  srbl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .lambdas   (lambda_r),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/srbl_front.sv =====
// Front end: takes a node beat, sums the active partials and classifies it.
module srbl_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  srbl_pkg::in_item_t in_data,
  input  logic [2:0]       num_states,
  input  logic             q_full,
  output logic             q_push,
  output srbl_pkg::node_t  q_entry
);
  import srbl_pkg::*;

  logic [2:0]             n_use;
  logic [33:0]            sum;
  logic [LANES-1:0][31:0] parts;

  assign parts = {in_data.partial_3, in_data.partial_2, in_data.partial_1, in_data.partial_0};
  assign n_use = (num_states > 3'(LANE_LIMIT)) ? 3'(LANE_LIMIT) : num_states;

  always_comb begin
    sum = '0;
    for (int s = 0; s < LANES; s++) begin
      if (3'(s) < n_use) sum = sum + {2'b00, parts[s]};
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_entry.len     = in_data.branch_length;
    q_entry.tip     = in_data.is_tip;
    q_entry.root    = in_data.is_root;
    q_entry.last    = in_data.last_node;
    q_entry.zsum    = (sum == '0);
    q_entry.n       = n_use;
    q_entry.sum     = sum;
    q_entry.partial = parts;
  end

endmodule

// ===== rtl/srbl_queue.sv =====
// Two-entry queue of classified nodes between front and back.
module srbl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srbl_pkg::node_t push_data,
  input  logic            pop,
  output srbl_pkg::node_t pop_data,
  output logic            full,
  output logic            not_empty
);
  import srbl_pkg::*;

  node_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/srbl_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
module srbl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  srbl_pkg::div_req_t req,
  output srbl_pkg::div_rsp_t rsp
);
  import srbl_pkg::*;

  logic [63:0] quot_r;
  logic [34:0] rem_r;
  logic [34:0] dsr_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [35:0] trial;
  logic        fits;

  assign trial = {rem_r, quot_r[63]} - {1'b0, dsr_r};
  assign fits  = !trial[35];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quot_r <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
        cnt_r  <= 7'd64;
      end else if (cnt_r != '0) begin
        rem_r  <= fits ? trial[34:0] : {rem_r[33:0], quot_r[63]};
        quot_r <= {quot_r[62:0], fits};
        cnt_r  <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) done_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== rtl/srbl_back.sv =====
// Back end: per-state exp, weighting, normalising, log and accumulation.
module srbl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  srbl_pkg::node_t     q_entry,
  output logic                q_pop,
  input  srbl_pkg::lam_arr_t  lambdas,
  output srbl_pkg::div_req_t  div_req,
  input  srbl_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output srbl_pkg::out_item_t out_data
);
  import srbl_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE  = 25'b1 << 0,  S_XDIV  = 25'b1 << 1,  S_XWAIT = 25'b1 << 2,
    S_TMUL  = 25'b1 << 3,  S_TCHK  = 25'b1 << 4,  S_YMUL  = 25'b1 << 5,
    S_YGET  = 25'b1 << 6,  S_HMUL  = 25'b1 << 7,  S_HDIV  = 25'b1 << 8,
    S_HWAIT = 25'b1 << 9,  S_ESH   = 25'b1 << 10, S_WGT   = 25'b1 << 11,
    S_WWAIT = 25'b1 << 12, S_QDIV  = 25'b1 << 13, S_QWAIT = 25'b1 << 14,
    S_M1    = 25'b1 << 15, S_M2    = 25'b1 << 16, S_M3    = 25'b1 << 17,
    S_LCHK  = 25'b1 << 18, S_NORM  = 25'b1 << 19, S_SQ    = 25'b1 << 20,
    S_SQG   = 25'b1 << 21, S_LMUL  = 25'b1 << 22, S_LADD  = 25'b1 << 23,
    S_FIN   = 25'b1 << 24
  } st_t;

  st_t                st_r;
  node_t              ent_r;
  logic [1:0]         lane_r;
  logic [23:0]        x_r;
  logic [4:0]         k_r;
  logic [29:0]        f_r;
  logic [29:0]        y_r;
  logic [30:0]        p_r;
  logic [3:0]         n_r;
  logic [30:0]        e_r;
  logic [46:0]        a_r;
  logic [30:0]        q_r;
  logic [46:0]        tmp_r;
  logic [49:0]        node_r;
  logic [31:0]        z_r;
  logic [5:0]         b_r;
  logic [3:0]         i_r;
  logic [15:0]        frac_r;
  logic               neg_r;
  logic [63:0]        prod_r;
  logic signed [47:0] acc_r;
  logic               inv_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [31:0]        ma;
  logic [31:0]        mb;
  logic [23:0]        lam;
  logic [33:0]        z2;
  logic signed [23:0] lval;
  logic [22:0]        lmag;
  logic signed [22:0] lnv;
  logic signed [48:0] acc_sum;
  logic [1:0]         h_pre;
  logic [31:0]        h_rec;
  logic [5:0]         h_sh;
  logic [30:0]        h_quot;
  logic               emit;

  // A zero rate counts as one LSB
  assign lam  = (lambdas[lane_r] == '0) ? 24'd1 : lambdas[lane_r];
  assign z2   = prod_r[63:30];
  assign lval = (24'(signed'({1'b0, b_r})) - 24'sd30) * 24'sd65536
                + signed'({8'd0, frac_r});
  assign lmag = lval[23] ? 23'(-lval) : lval[22:0];
  assign lnv  = neg_r ? -signed'({1'b0, prod_r[51:30]}) : signed'({1'b0, prod_r[51:30]});
  assign acc_sum = 49'(acc_r) + 49'(lnv);

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign emit  = (st_r == S_FIN) && ent_r.last && (!out_valid_r || out_ready);

  // Divide the series term by its index: pre-shift, reciprocal multiply, shift
  always_comb begin
    h_pre = 2'd0;
    h_rec = RECIP_1;
    h_sh  = 6'd31;
    unique case (n_r)
      4'd2: h_pre = 2'd1;
      4'd3: begin h_rec = RECIP_3; h_sh = 6'd33; end
      4'd4: h_pre = 2'd2;
      4'd5: begin h_rec = RECIP_5; h_sh = 6'd34; end
      4'd6: begin h_pre = 2'd1; h_rec = RECIP_3; h_sh = 6'd33; end
      4'd7: begin h_rec = RECIP_7; h_sh = 6'd34; end
      4'd8: h_pre = 2'd3;
      default: ;
    endcase
  end

  assign h_quot = 31'(prod_r >> h_sh);

  always_comb begin
    ma = '0;
    mb = '0;
    div_req = '0;
    unique case (st_r)
      S_XDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {24'd0, ent_r.len, 16'd0};
        div_req.divisor  = {11'd0, lam};
      end
      S_TMUL: begin ma = {8'd0, x_r}; mb = LOG2E_Q16; end
      S_YMUL: begin ma = {2'd0, f_r}; mb = LN2_Q30; end
      S_HMUL: begin ma = {2'd0, y_r}; mb = {1'b0, p_r}; end
      S_HDIV: begin ma = prod_r[61:30] >> h_pre; mb = h_rec; end
      S_WGT: begin
        div_req.start    = !ent_r.tip;
        div_req.dividend = {17'd0, e_r, 16'd0};
        div_req.divisor  = {11'd0, lam};
      end
      S_QDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {ent_r.partial[lane_r], 32'd0} >> 2;
        div_req.divisor  = {1'b0, ent_r.sum};
      end
      S_M1:   begin ma = {15'd0, a_r[46:30]}; mb = {1'b0, q_r}; end
      S_M2:   begin ma = {2'd0, a_r[29:0]}; mb = {1'b0, q_r}; end
      S_SQ:   begin ma = z_r; mb = z_r; end
      S_LMUL: begin ma = {9'd0, lmag}; mb = LN2_Q30; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      acc_r       <= '0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          ent_r  <= q_entry;
          lane_r <= '0;
          node_r <= '0;
          if (q_entry.root) st_r <= S_FIN;
          else if (q_entry.zsum) begin
            inv_r <= 1'b1;
            st_r  <= S_FIN;
          end else st_r <= S_XDIV;
        end
        S_XDIV: st_r <= S_XWAIT;
        S_XWAIT: if (div_rsp.done) begin
          x_r <= div_rsp.quot[23:0];
          if (div_rsp.quot[63:24] != '0) begin
            // exp underflows
            e_r  <= '0;
            st_r <= S_WGT;
          end else st_r <= S_TMUL;
        end
        S_TMUL: st_r <= S_TCHK;
        S_TCHK: begin
          f_r <= prod_r[31:2];
          k_r <= prod_r[36:32];
          if (prod_r[63:32] >= 32'd31) begin
            e_r  <= '0;
            st_r <= S_WGT;
          end else st_r <= S_YMUL;
        end
        S_YMUL: st_r <= S_YGET;
        S_YGET: begin
          y_r  <= prod_r[59:30];
          p_r  <= ONE_Q30;
          n_r  <= EXP_TERMS;
          st_r <= S_HMUL;
        end
        S_HMUL: st_r <= S_HDIV;
        S_HDIV: st_r <= S_HWAIT;
        S_HWAIT: begin
          p_r <= ONE_Q30 - h_quot;
          if (n_r == 4'd1) st_r <= S_ESH;
          else begin
            n_r  <= n_r - 4'd1;
            st_r <= S_HMUL;
          end
        end
        S_ESH: begin
          e_r  <= p_r >> k_r;
          st_r <= S_WGT;
        end
        S_WGT: begin
          if (ent_r.tip) begin
            a_r  <= {16'd0, e_r};
            st_r <= S_QDIV;
          end else st_r <= S_WWAIT;
        end
        S_WWAIT: if (div_rsp.done) begin
          a_r  <= div_rsp.quot[46:0];
          st_r <= S_QDIV;
        end
        S_QDIV: st_r <= S_QWAIT;
        S_QWAIT: if (div_rsp.done) begin
          q_r  <= div_rsp.quot[30:0];
          st_r <= S_M1;
        end
        S_M1: st_r <= S_M2;
        S_M2: begin
          tmp_r <= prod_r[46:0];
          st_r  <= S_M3;
        end
        S_M3: begin
          node_r <= node_r + 50'(tmp_r) + 50'(prod_r[63:30]);
          lane_r <= lane_r + 2'd1;
          if ((3'(lane_r) + 3'd1) < ent_r.n) st_r <= S_XDIV;
          else st_r <= S_LCHK;
        end
        S_LCHK: begin
          b_r    <= 6'd30;
          i_r    <= '0;
          frac_r <= '0;
          if (node_r == '0) begin
            inv_r <= 1'b1;
            st_r  <= S_FIN;
          end else st_r <= S_NORM;
        end
        S_NORM: begin
          // walk the leading one into bit 30, one place a cycle
          if (node_r[49:31] != '0) begin
            node_r <= node_r >> 1;
            b_r    <= b_r + 6'd1;
          end else if (!node_r[30]) begin
            node_r <= node_r << 1;
            b_r    <= b_r - 6'd1;
          end else begin
            z_r  <= node_r[31:0];
            st_r <= S_SQ;
          end
        end
        S_SQ: st_r <= S_SQG;
        S_SQG: begin
          if (z2 >= 34'h0_8000_0000) begin
            z_r    <= z2[32:1];
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            z_r    <= z2[31:0];
            frac_r <= {frac_r[14:0], 1'b0};
          end
          i_r <= i_r + 4'd1;
          if (i_r == LOG_LAST) st_r <= S_LMUL;
          else st_r <= S_SQ;
        end
        S_LMUL: begin
          neg_r <= lval[23];
          st_r  <= S_LADD;
        end
        S_LADD: begin
          if (acc_sum > ACC_MAX) acc_r <= ACC_MAX[47:0];
          else if (acc_sum < ACC_MIN) acc_r <= ACC_MIN[47:0];
          else acc_r <= acc_sum[47:0];
          st_r <= S_FIN;
        end
        S_FIN: begin
          if (!ent_r.last) st_r <= S_IDLE;
          else if (emit) begin
            out_data_r.log_likelihood <= inv_r ? '0 : acc_r;
            out_data_r.invalid        <= inv_r;
            acc_r                     <= '0;
            inv_r                     <= 1'b0;
            st_r                      <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/srbl_checker.sv =====
// Port-level checks of the branch log likelihood accumulator, bound to the top.
module srbl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input srbl_pkg::out_item_t out_data,
  input logic                cfg_ready
);
  import srbl_pkg::*;

  // Hold a stalled result beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.log_likelihood == '0)
    else $error("invalid result carries a nonzero total");

  assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");

endmodule

bind state_rate_branch_loglik srbl_checker u_srbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
